@@ src/olps_pkg.sv @@
// shared constants and types for the ordered list store
package olps_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int CW    = ((LW > 8) ? LW : 8) + 1;

    localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);

    localparam logic [2:0] CMD_INS_HEAD = 3'd0;
    localparam logic [2:0] CMD_INS_TAIL = 3'd1;
    localparam logic [2:0] CMD_INS_POS  = 3'd2;
    localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
    localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
    localparam logic [2:0] CMD_DEL_POS  = 3'd5;
    localparam logic [2:0] CMD_READ_OUT = 3'd6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

@@ src/olps_if.sv @@
// request and result channel interfaces of the ordered list store
interface olps_req_if;
    logic                valid;
    logic                ready;
    logic [2:0]          command;
    logic signed [31:0]  value;
    logic [7:0]          position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

interface olps_res_if;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic signed [31:0]  element;
    logic                final_item;

    modport source (output valid, status, element, final_item, input ready);
    modport sink   (input valid, status, element, final_item, output ready);
endinterface

@@ src/ordered_list_positional_store.sv @@
// ordered list store: list of signed values in a ram, shifted one cell per cycle
//
//   channel   dir   beat fields                         handshake
//   request   in    command, value, position            valid / ready
//   result    out   status, element, final_item         valid / ready
//
// one command at a time; request.ready is high only while idle
// insert moves the cells from index to tail up one place, then writes the value;
// delete moves later cells down one place; read out emits the elements in order
// reset clears length and the other registers; ram contents need no clearing
// a stalled result holds in the output register and the sequencer waits for it
module ordered_list_positional_store (
    input  logic          clk,
    input  logic          rst_n,
    olps_req_if.sink      request,
    olps_res_if.source    result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_DN,
        S_RD_ISSUE,
        S_RD_EMIT,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [olps_pkg::LW-1:0] length_reg, length_next;
    logic [olps_pkg::LW-1:0] ptr_reg, ptr_next;
    logic [olps_pkg::LW-1:0] idx_reg, idx_next;
    logic [olps_pkg::AW-1:0] wa_reg, wa_next;
    logic                    pend_reg, pend_next;
    logic [31:0]             val_reg, val_next;
    olps_pkg::status_t       stat_reg, stat_next;

    logic                    res_valid_reg, res_valid_next;
    logic [1:0]              res_status_reg, res_status_next;
    logic [31:0]             res_element_reg, res_element_next;
    logic                    res_final_reg, res_final_next;

    logic                    ram_wr_en;
    logic [olps_pkg::AW-1:0] ram_wr_addr;
    logic [31:0]             ram_wr_data;
    logic                    ram_rd_en;
    logic [olps_pkg::AW-1:0] ram_rd_addr;
    logic [31:0]             ram_rd_data;

    logic                    out_free;
    logic                    is_full;
    logic                    is_empty;
    logic [olps_pkg::CW-1:0] pos_ext;
    logic [olps_pkg::CW-1:0] len_ext;
    logic [olps_pkg::LW-1:0] pos_idx;
    logic [olps_pkg::LW-1:0] ptr_dec;
    logic [olps_pkg::LW-1:0] ptr_inc;

    olps_ram #(
        .WIDTH (32),
        .DEPTH (olps_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign request.ready     = (state_reg == S_IDLE);
    assign result.valid      = res_valid_reg;
    assign result.status     = res_status_reg;
    assign result.element    = $signed(res_element_reg);
    assign result.final_item = res_final_reg;

    assign out_free = !res_valid_reg || result.ready;
    assign is_full  = (length_reg == olps_pkg::FULL_LEN);
    assign is_empty = (length_reg == '0);
    assign pos_ext  = olps_pkg::CW'(request.position);
    assign len_ext  = olps_pkg::CW'(length_reg);
    assign pos_idx  = olps_pkg::LW'(pos_ext - olps_pkg::CW'(1));
    assign ptr_dec  = ptr_reg - 1'b1;
    assign ptr_inc  = ptr_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        length_next      = length_reg;
        ptr_next         = ptr_reg;
        idx_next         = idx_reg;
        wa_next          = wa_reg;
        pend_next        = pend_reg;
        val_next         = val_reg;
        stat_next        = stat_reg;
        res_valid_next   = res_valid_reg && !result.ready;
        res_status_next  = res_status_reg;
        res_element_next = res_element_reg;
        res_final_next   = res_final_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = wa_reg;
        ram_wr_data      = ram_rd_data;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = ptr_reg[olps_pkg::AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    val_next  = request.value;
                    pend_next = 1'b0;
                    stat_next = olps_pkg::ST_OK;
                    unique case (request.command)
                        olps_pkg::CMD_INS_HEAD, olps_pkg::CMD_INS_TAIL,
                        olps_pkg::CMD_INS_POS:
                        begin
                            ptr_next = length_reg;
                            if (request.command == olps_pkg::CMD_INS_HEAD)
                            begin
                                idx_next = '0;
                            end
                            else if (request.command == olps_pkg::CMD_INS_TAIL)
                            begin
                                idx_next = length_reg;
                            end
                            else
                            begin
                                idx_next = pos_idx;
                            end
                            if (is_full)
                            begin
                                stat_next  = olps_pkg::ST_FULL;
                                state_next = S_RESP;
                            end
                            else if (request.command == olps_pkg::CMD_INS_POS &&
                                     (pos_ext == '0 ||
                                      pos_ext > len_ext + olps_pkg::CW'(1)))
                            begin
                                stat_next  = olps_pkg::ST_RANGE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_UP;
                            end
                        end
                        olps_pkg::CMD_DEL_HEAD, olps_pkg::CMD_DEL_TAIL,
                        olps_pkg::CMD_DEL_POS:
                        begin
                            if (request.command == olps_pkg::CMD_DEL_HEAD)
                            begin
                                ptr_next = '0;
                            end
                            else if (request.command == olps_pkg::CMD_DEL_TAIL)
                            begin
                                ptr_next = length_reg - 1'b1;
                            end
                            else
                            begin
                                ptr_next = pos_idx;
                            end
                            if (is_empty)
                            begin
                                stat_next  = olps_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else if (request.command == olps_pkg::CMD_DEL_POS &&
                                     (pos_ext == '0 || pos_ext > len_ext))
                            begin
                                stat_next  = olps_pkg::ST_RANGE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DN;
                            end
                        end
                        olps_pkg::CMD_READ_OUT:
                        begin
                            ptr_next = '0;
                            if (is_empty)
                            begin
                                stat_next  = olps_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RD_ISSUE;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                ram_wr_en = pend_reg;
                if (ptr_reg > idx_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_dec[olps_pkg::AW-1:0];
                    wa_next     = ptr_reg[olps_pkg::AW-1:0];
                    ptr_next    = ptr_dec;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg[olps_pkg::AW-1:0];
                ram_wr_data = val_reg;
                length_next = length_reg + 1'b1;
                state_next  = S_RESP;
            end
            S_DN:
            begin
                ram_wr_en = pend_reg;
                if (ptr_inc < length_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_inc[olps_pkg::AW-1:0];
                    wa_next     = ptr_reg[olps_pkg::AW-1:0];
                    ptr_next    = ptr_inc;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next   = 1'b0;
                    length_next = length_reg - 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_RD_ISSUE:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next   = 1'b1;
                    res_status_next  = olps_pkg::ST_OK;
                    res_element_next = ram_rd_data;
                    res_final_next   = (ptr_inc == length_reg);
                    ptr_next         = ptr_inc;
                    state_next       = (ptr_inc == length_reg) ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    res_valid_next   = 1'b1;
                    res_status_next  = stat_reg;
                    res_element_next = '0;
                    res_final_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            length_reg      <= '0;
            ptr_reg         <= '0;
            idx_reg         <= '0;
            wa_reg          <= '0;
            pend_reg        <= 1'b0;
            val_reg         <= '0;
            stat_reg        <= olps_pkg::ST_OK;
            res_valid_reg   <= 1'b0;
            res_status_reg  <= '0;
            res_element_reg <= '0;
            res_final_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            length_reg      <= length_next;
            ptr_reg         <= ptr_next;
            idx_reg         <= idx_next;
            wa_reg          <= wa_next;
            pend_reg        <= pend_next;
            val_reg         <= val_next;
            stat_reg        <= stat_next;
            res_valid_reg   <= res_valid_next;
            res_status_reg  <= res_status_next;
            res_element_reg <= res_element_next;
            res_final_reg   <= res_final_next;
        end
    end

endmodule

@@ src/olps_ram.sv @@
// generic single write port ram with registered read
module olps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                    wr_data,
    input  logic                                rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                    rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the ordered list store, with a list predictor and random traffic
module testbench;

    localparam int         CLK_PERIOD       = 20;
    localparam int         RESET_CYCLES     = 7;
    localparam int         SETTLE_CYCLES    = 80;
    localparam int         MAX_REPORTS      = 10;
    localparam int         PHASE_ITEMS      = 120;
    localparam int         RUN_LIMIT_CYCLES = 1_000_000;
    localparam logic [2:0] CMD_UNUSED       = 3'd7;

    typedef struct packed {
        olps_pkg::status_t  status;
        logic signed [31:0] element;
        logic               final_item;
    } list_beat_t;

    typedef enum logic [1:0] {
        WALK_GROW,
        WALK_SHRINK,
        WALK_WANDER
    } walk_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    olps_req_if req_bus();
    olps_res_if res_bus();

    ordered_list_positional_store dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_bus),
        .result  (res_bus)
    );

    logic signed [31:0] list_copy[$];
    list_beat_t         pending_beats[$];
    int                 error_count     = 0;
    int                 sender_idle_pct = 0;
    int                 sink_stall_pct  = 0;
    walk_mode_t         walk_mode       = WALK_GROW;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void expect_status(olps_pkg::status_t st);
        list_beat_t beat;
        beat.status     = st;
        beat.element    = '0;
        beat.final_item = 1'b1;
        pending_beats.push_back(beat);
    endfunction

    // list behavior: works out the beats a command causes and updates the copy
    function automatic void predict_command(logic [2:0] cmd, logic signed [31:0] val,
                                            logic [7:0] pos);
        int         len;
        int         slot;
        int         idx;
        list_beat_t beat;
        len  = list_copy.size();
        slot = int'(pos);
        case (cmd)
            olps_pkg::CMD_INS_HEAD, olps_pkg::CMD_INS_TAIL, olps_pkg::CMD_INS_POS:
            begin
                if (len >= olps_pkg::DEPTH)
                    expect_status(olps_pkg::ST_FULL);
                else if (cmd == olps_pkg::CMD_INS_POS && (slot < 1 || slot > len + 1))
                    expect_status(olps_pkg::ST_RANGE);
                else
                begin
                    if (cmd == olps_pkg::CMD_INS_HEAD)
                        list_copy.push_front(val);
                    else if (cmd == olps_pkg::CMD_INS_TAIL)
                        list_copy.push_back(val);
                    else
                        list_copy.insert(slot - 1, val);
                    expect_status(olps_pkg::ST_OK);
                end
            end
            olps_pkg::CMD_DEL_HEAD, olps_pkg::CMD_DEL_TAIL, olps_pkg::CMD_DEL_POS:
            begin
                if (len == 0)
                    expect_status(olps_pkg::ST_EMPTY);
                else if (cmd == olps_pkg::CMD_DEL_POS && (slot < 1 || slot > len))
                    expect_status(olps_pkg::ST_RANGE);
                else
                begin
                    if (cmd == olps_pkg::CMD_DEL_HEAD)
                        list_copy.delete(0);
                    else if (cmd == olps_pkg::CMD_DEL_TAIL)
                        list_copy.delete(len - 1);
                    else
                        list_copy.delete(slot - 1);
                    expect_status(olps_pkg::ST_OK);
                end
            end
            olps_pkg::CMD_READ_OUT:
            begin
                if (len == 0)
                    expect_status(olps_pkg::ST_EMPTY);
                else
                begin
                    for (idx = 0; idx < len; idx++)
                    begin
                        beat.status     = olps_pkg::ST_OK;
                        beat.element    = list_copy[idx];
                        beat.final_item = (idx == len - 1);
                        pending_beats.push_back(beat);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void note_mismatch(string what, list_beat_t want, list_beat_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t mismatch, %s: expected status %0d element %0d last %0b, %s %0d %s %0d %s %0b",
                     $time, what, want.status, want.element, want.final_item,
                     "got status", got.status, "element", got.element, "last",
                     got.final_item);
    endfunction

    task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] val,
                                input logic [7:0] pos);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.command  <= cmd;
        req_bus.value    <= val;
        req_bus.position <= pos;
        do
            @(posedge clk);
        while (!req_bus.ready);
        predict_command(cmd, val, pos);
    endtask

    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_beats.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // mostly legal positions, some just outside, some anywhere in the field
    function automatic logic [7:0] pick_position(int limit);
        int roll;
        roll = $urandom_range(99);
        if (roll < 80 && limit >= 1)
            return 8'($urandom_range(limit, 1));
        else if (roll < 90)
            return ($urandom_range(1) != 0) ? 8'd0 : 8'(limit + 1);
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic send_random_command();
        int                 len;
        int                 roll;
        int                 insert_cut;
        logic [2:0]         cmd;
        logic [7:0]         pos;
        len = list_copy.size();
        if (walk_mode == WALK_GROW && len == olps_pkg::DEPTH && $urandom_range(5) == 0)
            walk_mode = WALK_SHRINK;
        else if (walk_mode == WALK_SHRINK && len == 0 && $urandom_range(5) == 0)
            walk_mode = ($urandom_range(1) != 0) ? WALK_GROW : WALK_WANDER;
        else if (walk_mode == WALK_WANDER && $urandom_range(39) == 0)
            walk_mode = WALK_GROW;
        case (walk_mode)
            WALK_GROW:   insert_cut = 78;
            WALK_SHRINK: insert_cut = 30;
            default:     insert_cut = 54;
        endcase
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            cmd = olps_pkg::CMD_READ_OUT;
            pos = 8'($urandom_range(255, 0));
        end
        else if (roll < insert_cut)
        begin
            case ($urandom_range(2))
                0: cmd = olps_pkg::CMD_INS_HEAD;
                1: cmd = olps_pkg::CMD_INS_TAIL;
                default: cmd = olps_pkg::CMD_INS_POS;
            endcase
            pos = pick_position(len + 1);
        end
        else
        begin
            case ($urandom_range(2))
                0: cmd = olps_pkg::CMD_DEL_HEAD;
                1: cmd = olps_pkg::CMD_DEL_TAIL;
                default: cmd = olps_pkg::CMD_DEL_POS;
            endcase
            pos = pick_position(len);
        end
        send_command(cmd, pick_value(), pos);
        // unused code slipped in now and then
        if ($urandom_range(49) == 0)
            send_command(CMD_UNUSED, pick_value(), 8'($urandom_range(255, 0)));
    endtask

    task automatic run_random_phase(int items, int idle_pct, int stall_pct);
        int n;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        for (n = 0; n < items; n++)
        begin
            send_random_command();
            if (n == items / 2)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    task automatic test_empty_list();
        send_command(olps_pkg::CMD_READ_OUT, 32'sd0, 8'd0);
        send_command(olps_pkg::CMD_DEL_HEAD, 32'sd0, 8'd0);
        send_command(olps_pkg::CMD_DEL_TAIL, 32'sd0, 8'd0);
        send_command(olps_pkg::CMD_DEL_POS, 32'sd0, 8'd1);
        send_command(olps_pkg::CMD_DEL_POS, 32'sd0, 8'd0);
        send_command(CMD_UNUSED, 32'sh7FFF_FFFF, 8'd255);
    endtask

    task automatic test_edge_inserts();
        send_command(olps_pkg::CMD_INS_HEAD, 32'sh7FFF_FFFF, 8'd0);
        send_command(olps_pkg::CMD_INS_TAIL, 32'sh8000_0000, 8'd255);
        send_command(olps_pkg::CMD_INS_POS, 32'sd5, 8'd0);
        send_command(olps_pkg::CMD_INS_POS, 32'sd6, 8'd4);
        send_command(olps_pkg::CMD_INS_POS, -32'sd1, 8'd3);
        send_command(olps_pkg::CMD_INS_POS, 32'sd0, 8'd1);
        send_command(olps_pkg::CMD_INS_POS, 32'sd7, 8'd255);
        send_command(olps_pkg::CMD_READ_OUT, 32'sd0, 8'd0);
    endtask

    task automatic test_edge_deletes();
        send_command(olps_pkg::CMD_DEL_POS, 32'sd0, 8'd5);
        send_command(olps_pkg::CMD_DEL_POS, 32'sd0, 8'd255);
        send_command(olps_pkg::CMD_DEL_POS, 32'sd0, 8'd2);
        send_command(olps_pkg::CMD_DEL_HEAD, 32'sd0, 8'd0);
        send_command(olps_pkg::CMD_DEL_TAIL, 32'sd0, 8'd0);
        send_command(olps_pkg::CMD_READ_OUT, 32'sd0, 8'd0);
        send_command(olps_pkg::CMD_DEL_TAIL, 32'sd0, 8'd0);
        send_command(olps_pkg::CMD_DEL_HEAD, 32'sd0, 8'd0);
    endtask

    task automatic test_random_no_idle();
        run_random_phase(PHASE_ITEMS, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(PHASE_ITEMS, 67, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(PHASE_ITEMS, 0, 67);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(PHASE_ITEMS, 23, 23);
    endtask

    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        list_beat_t want;
        list_beat_t got;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got.status     = olps_pkg::status_t'(res_bus.status);
            got.element    = res_bus.element;
            got.final_item = res_bus.final_item;
            if (pending_beats.size() == 0)
            begin
                want = '0;
                note_mismatch("beat with nothing pending", want, got);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (res_bus.status !== want.status || res_bus.element !== want.element ||
                    res_bus.final_item !== want.final_item)
                    note_mismatch("field differs", want, got);
            end
        end
    end

    initial
    begin
        req_bus.valid    <= 1'b0;
        req_bus.command  <= olps_pkg::CMD_INS_HEAD;
        req_bus.value    <= '0;
        req_bus.position <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edge_inserts();
        test_edge_deletes();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            error_count += pending_beats.size();
            $display("%0d expected beats never arrived", pending_beats.size());
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
